### sv/rled_pkg.sv
// -----------------------------------------------------------------------------
// rled_pkg
// Shared types and constants for the run-length RGB image decoder.
// -----------------------------------------------------------------------------
package rled_pkg;

   // Pixels carried by one result transfer.
   localparam int PIXELS_PER_RESULT = 4;
   localparam int PIX_CNT_W         = 3;

   // Header layout and the only accepted colour depth.
   localparam logic [3:0]  HEADER_LAST_IDX = 4'd9;
   localparam logic [3:0]  DEPTH_POS       = 4'd8;
   localparam logic [3:0]  HEIGHT_POS      = 4'd2;
   localparam logic [3:0]  WIDTH_END       = 4'd2;
   localparam logic [3:0]  HEIGHT_END      = 4'd4;
   localparam logic [15:0] DEPTH_REQUIRED  = 16'h0018;

   // Job queue between the parser and the expander.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam logic REG_HEADER_ORDER = 1'b0;

   // Parser phase.
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_DATA   = 2'd1,
      PH_IDLE   = 2'd2
   } phase_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_BUSY      = 2'd0,
      ST_BAD_DEPTH = 2'd1,
      ST_DONE      = 2'd2
   } status_type;

   // One unit of work for the expander: a run of equal pixels, or a
   // pixel-free status report when count is zero.
   typedef struct packed {
      logic [7:0]  count;
      logic [23:0] pixel;
      status_type  status;
   } job_type;

endpackage

### sv/rled_front.sv
// -----------------------------------------------------------------------------
// rled_front
// Byte parser: decodes the header and the run records and queues one job per
// record that yields results, and one status job for a bad depth.
// -----------------------------------------------------------------------------
module rled_front
   import rled_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          little_endian,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    file_byte,
   input  logic          file_start,
   input  logic          queue_full,
   output logic          push_valid,
   output job_type       push_job
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [15:0] depth_ff, depth_in;
   logic [16:0] column_ff, column_in;
   logic [15:0] row_ff, row_in;
   logic [7:0]  run_ff, run_in;
   logic [15:0] colour_ff, colour_in;

   phase_type   phase_v;
   logic [3:0]  idx_v;
   logic [16:0] column_v;
   logic [15:0] row_v;
   logic [7:0]  run_v;
   logic [15:0] colour_v;
   logic        accept;
   logic        high_half;
   logic [16:0] col_sum;
   logic [16:0] row_sum;
   logic        done;
   logic [1:0]  rec_idx;

   // A byte is taken whenever the job queue has room for what it may cause.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Clocked parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         idx_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         depth_ff  <= '0;
         column_ff <= '0;
         row_ff    <= '0;
         run_ff    <= '0;
         colour_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         run_ff    <= run_in;
         colour_ff <= colour_in;
      end
   end

   // Next state and job generation for the byte at the input.
   always_comb begin
      // A file start restarts parsing with this byte as header byte zero.
      phase_v  = file_start ? PH_HEADER : phase_ff;
      idx_v    = file_start ? 4'd0 : idx_ff;
      column_v = file_start ? 17'd0 : column_ff;
      row_v    = file_start ? 16'd0 : row_ff;
      run_v    = file_start ? 8'd0 : run_ff;
      colour_v = file_start ? 16'd0 : colour_ff;

      phase_in  = phase_v;
      idx_in    = idx_v;
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      column_in = column_v;
      row_in    = row_v;
      run_in    = run_v;
      colour_in = colour_v;

      high_half = little_endian ? idx_v[0] : !idx_v[0];
      col_sum   = column_v + {9'd0, run_v};
      row_sum   = {1'b0, row_v} + 17'd1;
      done      = 1'b0;
      rec_idx   = idx_v[1:0];

      push_valid      = 1'b0;
      push_job.count  = run_v;
      push_job.pixel  = {colour_v, file_byte};
      push_job.status = ST_BUSY;

      case (phase_v)
         PH_HEADER: begin
            // Collect the 16-bit header words in the configured byte order.
            if (idx_v < WIDTH_END) begin
               width_in = high_half ? {file_byte, width_ff[7:0]}
                                    : {width_ff[15:8], file_byte};
            end else if (idx_v >= HEIGHT_POS && idx_v < HEIGHT_END) begin
               height_in = high_half ? {file_byte, height_ff[7:0]}
                                     : {height_ff[15:8], file_byte};
            end else if (idx_v >= DEPTH_POS) begin
               depth_in = high_half ? {file_byte, depth_ff[7:0]}
                                    : {depth_ff[15:8], file_byte};
            end
            idx_in = idx_v + 4'd1;
            // At the end of the header, check the depth: start the data or report and idle.
            if (idx_v >= HEADER_LAST_IDX) begin
               idx_in    = 4'd0;
               column_in = 17'd0;
               row_in    = 16'd0;
               if (depth_in != DEPTH_REQUIRED) begin
                  push_valid      = 1'b1;
                  push_job.count  = 8'd0;
                  push_job.status = ST_BAD_DEPTH;
                  phase_in        = PH_IDLE;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            case (rec_idx)
               2'd0: run_in = file_byte;
               2'd1: colour_in = {file_byte, 8'd0};
               2'd2: colour_in = {colour_v[15:8], file_byte};
               default: begin
                  // Last byte of the record: advance column and row.
                  if (col_sum >= {1'b0, width_ff}) begin
                     column_in = 17'd0;
                     row_in    = row_sum[15:0];
                     done      = row_sum >= {1'b0, height_ff};
                  end else begin
                     column_in = col_sum;
                  end
                  push_valid      = (run_v != 8'd0) || done;
                  push_job.status = done ? ST_DONE : ST_BUSY;
                  if (done) begin
                     phase_in = PH_IDLE;
                  end
               end
            endcase
            idx_in = {2'd0, rec_idx + 2'd1};
         end
         default: begin
            // Bytes after completion or an error are dropped.
         end
      endcase

      push_valid = push_valid && accept;
   end

endmodule

### sv/rled_queue.sv
// -----------------------------------------------------------------------------
// rled_queue
// Short first-word-fall-through job queue between parser and expander.
// -----------------------------------------------------------------------------
module rled_queue
   import rled_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    full,
   output logic    head_valid,
   output job_type head_job,
   input  logic    pop
);

   job_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  fill_ff;
   logic                    do_pop;

   assign full       = fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Storage: written at the tail, no reset needed.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push_valid && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (!push_valid && do_pop) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

### sv/rled_back.sv
// -----------------------------------------------------------------------------
// rled_back
// Run expander: turns the job at the queue head into result transfers of up
// to four pixels each, held in an output register.
// -----------------------------------------------------------------------------
module rled_back
   import rled_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  job_type              head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [23:0]          rsp_pixel_a,
   output logic [23:0]          rsp_pixel_b,
   output logic [23:0]          rsp_pixel_c,
   output logic [23:0]          rsp_pixel_d,
   output logic [PIX_CNT_W-1:0] rsp_pixel_count,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);

   logic [7:0]           sent_ff, sent_in;
   logic                 valid_ff, valid_in;
   logic [23:0]          pix_ff [PIXELS_PER_RESULT];
   logic [23:0]          pix_in [PIXELS_PER_RESULT];
   logic [PIX_CNT_W-1:0] cnt_ff, cnt_in;
   status_type           status_ff, status_in;
   logic                 last_ff, last_in;
   logic [7:0]           left;
   logic                 out_free;
   logic                 emit;
   logic                 final_group;

   // Pixels of the current run not yet sent.
   assign left        = head_job.count - sent_ff;
   assign out_free    = !valid_ff || rsp_ready;
   assign emit        = head_valid && out_free;
   assign final_group = left <= 8'(PIXELS_PER_RESULT);
   assign pop         = emit && final_group;

   // Build the next result from the head job.
   always_comb begin
      cnt_in    = final_group ? left[PIX_CNT_W-1:0] : PIX_CNT_W'(PIXELS_PER_RESULT);
      status_in = final_group ? head_job.status : ST_BUSY;
      last_in   = final_group;
      for (int j = 0; j < PIXELS_PER_RESULT; j++) begin
         pix_in[j] = (PIX_CNT_W'(j) < cnt_in) ? head_job.pixel : 24'd0;
      end
      sent_in  = final_group ? 8'd0 : sent_ff + 8'(PIXELS_PER_RESULT);
      valid_in = emit ? 1'b1 : (valid_ff && !rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         if (emit) begin
            sent_ff <= sent_in;
         end
      end
   end

   // Output payload register, loaded once the previous transfer has left.
   always_ff @(posedge clock) begin
      if (emit) begin
         pix_ff    <= pix_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_a     = pix_ff[0];
   assign rsp_pixel_b     = pix_ff[1];
   assign rsp_pixel_c     = pix_ff[2];
   assign rsp_pixel_d     = pix_ff[3];
   assign rsp_pixel_count = cnt_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

endmodule

### sv/rgb_run_length_image_decoder.sv
// -----------------------------------------------------------------------------
// rgb_run_length_image_decoder
// Decodes a run-length coded 24-bit RGB image fed one file byte at a time.
// -----------------------------------------------------------------------------
// Usage:
// The req channel carries one file byte per transfer with file_start marking
// the first byte of a new file. A 10-byte header gives width, height and depth;
// a depth other than 24 yields one status transfer and the file is dropped.
// Each later 4-byte record (count, three colour bytes) expands to count pixels.
// The rsp channel carries up to four pixels per transfer with pixel_count,
// status and last (set on the final transfer caused by one input byte).
// Path: the fourth byte of a record reaches its first result transfer through
// the parser, the job queue and the output register.
// Throughput: one input byte per cycle while the job queue has room; a record
// of n pixels needs ceil(n/4) expander transfers, at least one when it yields a
// result, so the expander and the two-entry job queue set the sustained byte rate.
// When the receiver stalls, the output register holds its transfer, the queue
// fills and req_ready drops; nothing is lost.
// Reset clears the parser to header phase, empties the queue and sets the
// header byte order register (APB, address 0, bit 0) to big-endian.
// -----------------------------------------------------------------------------
module rgb_run_length_image_decoder
   import rled_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Configuration port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   // Input byte channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_file_byte,
   input  logic                 req_file_start,
   // Result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [23:0]          rsp_pixel_a,
   output logic [23:0]          rsp_pixel_b,
   output logic [23:0]          rsp_pixel_c,
   output logic [23:0]          rsp_pixel_d,
   output logic [PIX_CNT_W-1:0] rsp_pixel_count,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);

   logic    little_endian_ff;
   logic    csr_write;
   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   // Configuration register: header byte order.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_HEADER_ORDER);

   always_ff @(posedge clock) begin
      if (reset) begin
         little_endian_ff <= 1'b0;
      end else if (csr_write) begin
         little_endian_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr[2] == REG_HEADER_ORDER) ? {31'd0, little_endian_ff} : 32'd0;

   // Header and record parser.
   rled_front u_front (
      .clock         (clock),
      .reset         (reset),
      .little_endian (little_endian_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .file_byte     (req_file_byte),
      .file_start    (req_file_start),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_job      (push_job)
   );

   // Job queue.
   rled_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   // Run expander and output register.
   rled_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_a     (rsp_pixel_a),
      .rsp_pixel_b     (rsp_pixel_b),
      .rsp_pixel_c     (rsp_pixel_c),
      .rsp_pixel_d     (rsp_pixel_d),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
